>>> design/r2a_pkg.sv
package r2a_pkg;

  localparam int RADIX_W = 5;
  localparam int DIGIT_W = 4;
  localparam int CHAR_W  = 7;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;
  localparam logic [RADIX_W-1:0] RADIX_RST = 5'd16;

  localparam logic [CHAR_W-1:0]  ASCII_ZERO = 7'h30;
  localparam logic [CHAR_W-1:0]  ASCII_A    = 7'h41;
  localparam logic [DIGIT_W-1:0] DIGIT_TEN  = 4'd10;

  typedef struct packed {
    logic ld;
    logic go;
  } div_ctl_t;

  typedef struct packed {
    logic               done;
    logic               q_zero;
    logic [DIGIT_W-1:0] rem;
  } div_sts_t;

  function automatic logic [CHAR_W-1:0] ascii_of(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] r;
    if (d >= DIGIT_TEN) begin
      r = ASCII_A + {3'b000, d - DIGIT_TEN};
    end else begin
      r = ASCII_ZERO + {3'b000, d};
    end
    return r;
  endfunction

endpackage

>>> design/r2a_div.sv
module r2a_div #(
  parameter int VALUE_BITS = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  r2a_pkg::div_ctl_t           ctl,
  input  logic [VALUE_BITS-1:0]       value,
  input  logic [r2a_pkg::RADIX_W-1:0] radix,
  output r2a_pkg::div_sts_t           sts
);

  localparam int BCW = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
  localparam logic [BCW-1:0] LAST_BIT = BCW'(VALUE_BITS - 1);

  logic [VALUE_BITS-1:0]         q_r, q_nxt;
  logic [r2a_pkg::DIGIT_W-1:0]   rem_r, rem_nxt;
  logic [BCW-1:0]                bcnt_r;
  logic                          run_r;
  logic                          done_r;
  logic [r2a_pkg::RADIX_W-1:0]   trial;
  logic                          ge;

  always_comb begin
    trial   = {rem_r, q_r[VALUE_BITS-1]};
    ge      = (trial >= radix);
    rem_nxt = ge ? r2a_pkg::DIGIT_W'(trial - radix) : trial[r2a_pkg::DIGIT_W-1:0];
    q_nxt   = {q_r[VALUE_BITS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      bcnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.ld || ctl.go) begin
        run_r  <= 1'b1;
        bcnt_r <= '0;
      end else if (run_r) begin
        bcnt_r <= bcnt_r + 1'b1;
        if (bcnt_r == LAST_BIT) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld) begin
      q_r   <= value;
      rem_r <= '0;
    end else if (ctl.go) begin
      rem_r <= '0;
    end else if (run_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign sts.done   = done_r;
  assign sts.q_zero = (q_r == '0);
  assign sts.rem    = rem_r;

endmodule

>>> design/r2a_stack.sv
module r2a_stack #(
  parameter int DEPTH = 64
) (
  input  logic                              clk,
  input  logic                              wr_en,
  input  logic [$clog2(DEPTH)-1:0]          wr_addr,
  input  logic [r2a_pkg::DIGIT_W-1:0]       wr_data,
  input  logic [$clog2(DEPTH)-1:0]          rd_addr,
  output logic [r2a_pkg::DIGIT_W-1:0]       rd_data
);

  logic [r2a_pkg::DIGIT_W-1:0] mem [DEPTH];
  logic [r2a_pkg::DIGIT_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> design/radix_to_ascii_converter.sv
// Unsigned integer to ASCII text in a radix from 2 to 16.
// Input channel in_valid/in_ready carries one value; only its low VALUE_BITS
// bits are converted. Output channel out_valid/out_ready carries one character
// per item, most significant digit first, digits 10-15 as 'A'-'F'.
// out_last_digit marks the final character; zero gives the single item "0".
// A radix outside 2..16 gives one item with out_invalid_radix and
// out_last_digit set and out_digit_char zero, valid the cycle after acceptance.
// cfg_radix is written when cfg_wr_en is high; write only while idle.
// Each digit comes from a bit-serial restoring divider and is pushed on a digit
// stack; the characters are then read back from the stack, each through states
// ST_LOAD and ST_SHOW. One value is in flight at a time; in_ready is high only
// when idle, so the next value is taken the cycle after the last character goes
// out. A stalled receiver holds the current character; the block waits.
// Reset (rst_n low, synchronous) returns to idle with radix 16.
module radix_to_ascii_converter #(
  parameter int VALUE_BITS = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [63:0]                 in_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [r2a_pkg::CHAR_W-1:0]  out_digit_char,
  output logic                        out_last_digit,
  output logic                        out_invalid_radix,
  input  logic                        cfg_wr_en,
  input  logic [r2a_pkg::RADIX_W-1:0] cfg_radix
);

  localparam int AW = $clog2(VALUE_BITS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_LOAD,
    ST_SHOW
  } state_t;

  state_t                        state_r;
  logic                          inv_r;
  logic [AW-1:0]                 cnt_r;
  logic [AW-1:0]                 ptr_r;
  logic [r2a_pkg::RADIX_W-1:0]   radix_r;

  logic                          radix_ok;
  logic                          in_acc;
  r2a_pkg::div_ctl_t             div_ctl;
  r2a_pkg::div_sts_t             div_sts;
  logic                          push;
  logic [r2a_pkg::DIGIT_W-1:0]   top_digit;

  assign radix_ok = radix_r inside {[r2a_pkg::RADIX_MIN:r2a_pkg::RADIX_MAX]};
  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign push     = (state_r == ST_DIV) && div_sts.done;

  always_comb begin
    div_ctl.ld = in_acc && radix_ok;
    div_ctl.go = push && !div_sts.q_zero;
  end

  r2a_div #(
    .VALUE_BITS(VALUE_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (div_ctl),
    .value (in_value[VALUE_BITS-1:0]),
    .radix (radix_r),
    .sts   (div_sts)
  );

  r2a_stack #(
    .DEPTH(VALUE_BITS)
  ) u_stack (
    .clk     (clk),
    .wr_en   (push),
    .wr_addr (cnt_r),
    .wr_data (div_sts.rem),
    .rd_addr (ptr_r),
    .rd_data (top_digit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= r2a_pkg::RADIX_RST;
    end else if (cfg_wr_en) begin
      radix_r <= cfg_radix;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      inv_r   <= 1'b0;
      cnt_r   <= '0;
      ptr_r   <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            cnt_r <= '0;
            if (radix_ok) begin
              inv_r   <= 1'b0;
              state_r <= ST_DIV;
            end else begin
              inv_r   <= 1'b1;
              state_r <= ST_SHOW;
            end
          end
        end
        ST_DIV: begin
          if (div_sts.done) begin
            cnt_r <= cnt_r + 1'b1;
            if (div_sts.q_zero) begin
              ptr_r   <= cnt_r;
              state_r <= ST_LOAD;
            end
          end
        end
        ST_LOAD: begin
          state_r <= ST_SHOW;
        end
        ST_SHOW: begin
          if (out_ready) begin
            if (inv_r || ptr_r == '0) begin
              state_r <= ST_IDLE;
            end else begin
              ptr_r   <= ptr_r - 1'b1;
              state_r <= ST_LOAD;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid         = (state_r == ST_SHOW);
  assign out_invalid_radix = inv_r;
  assign out_last_digit    = inv_r || (ptr_r == '0);
  assign out_digit_char    = inv_r ? '0 : r2a_pkg::ascii_of(top_digit);

endmodule
